[sv/rlai_pkg.sv]
// Package for the rate-limited actuation interlock: payload and config types,
// register indexes, decision codes and timing constants. No dependencies.
package rlai_pkg;

    localparam int unsigned CfgAddrW = 5;

    // Register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_DRY_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_AUTO_ENABLE   = 3'd1;
    localparam logic [2:0] REG_MIN_INT_SECS  = 3'd2;
    localparam logic [2:0] REG_MIN_INT_TICKS = 3'd3;
    localparam logic [2:0] REG_MAX_DAILY     = 3'd4;

    localparam logic [1:0] DEC_HOLD    = 2'd0;
    localparam logic [1:0] DEC_REQUEST = 2'd1;
    localparam logic [1:0] DEC_BLOCKED = 2'd2;

    localparam logic CMD_EVALUATE = 1'b0;
    localparam logic CMD_REPORT   = 1'b1;

    localparam logic [31:0] NO_TIME      = 32'hFFFF_FFFF;
    localparam logic [15:0] NO_DAY       = 16'hFFFF;
    localparam logic [31:0] TICKS_IN_DAY = 32'd8640000;

    // floor(now / 86400) = ((now >> 7) * DAY_RECIP) >> DAY_SHIFT, exact for 25-bit operands
    localparam logic [25:0] DAY_RECIP = 26'd50903317;
    localparam int unsigned DAY_SHIFT = 35;

    localparam logic [9:0]  RST_DRY_THRESHOLD = 10'd300;
    localparam logic        RST_AUTO_ENABLE   = 1'b0;
    localparam logic [31:0] RST_MIN_INT_SECS  = 32'd3600;
    localparam logic [31:0] RST_MIN_INT_TICKS = 32'd360000;
    localparam logic [7:0]  RST_MAX_DAILY     = 8'd3;

    typedef struct packed {
        logic [9:0]  dry_threshold_permille;
        logic        auto_enable;
        logic [31:0] min_interval_seconds;
        logic [31:0] min_interval_ticks;
        logic [7:0]  max_daily_count;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic        dry_stress_flag;
        logic [9:0]  moisture_permille;
        logic        sensor_ok;
        logic        tank_has_liquid;
        logic [31:0] now_seconds;
        logic [31:0] tick_now;
        logic        last_response_failed;
        logic        monitoring_mode;
    } item_t;

endpackage

[sv/rlai_if.sv]
// Valid/ready channel interfaces for the interlock's input items and results.
// Uses nothing outside this file.
interface rlai_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        dry_stress_flag;
    logic [9:0]  moisture_permille;
    logic        sensor_ok;
    logic        tank_has_liquid;
    logic [31:0] now_seconds;
    logic [31:0] tick_now;
    logic        last_response_failed;
    logic        monitoring_mode;

    modport source (
        output valid, command, dry_stress_flag, moisture_permille, sensor_ok,
               tank_has_liquid, now_seconds, tick_now, last_response_failed,
               monitoring_mode,
        input  ready
    );
    modport sink (
        input  valid, command, dry_stress_flag, moisture_permille, sensor_ok,
               tank_has_liquid, now_seconds, tick_now, last_response_failed,
               monitoring_mode,
        output ready
    );
endinterface

interface rlai_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] decision;
    logic [7:0] daily_count_now;

    modport source (output valid, decision, daily_count_now, input ready);
    modport sink (input valid, decision, daily_count_now, output ready);
endinterface

[sv/rlai_core.sv]
// Decision and day-count datapath: input register, interlock state, result register.
// Depends on rlai_pkg and the channel interfaces in rlai_if.sv.
module rlai_core (
    input  logic            clk,
    input  logic            rst_n,
    input  rlai_pkg::cfg_t  cfg,
    rlai_in_if.sink         in_ch,
    rlai_out_if.source      out_ch
);
    import rlai_pkg::*;

    logic        in_vld_reg;
    item_t       item_reg;
    logic [15:0] day_idx_reg;
    logic        out_vld_reg;
    logic [1:0]  decision_reg;
    logic [7:0]  count_reg;

    logic [31:0] last_sec_reg;
    logic [31:0] last_tick_reg;
    logic [7:0]  day_count_reg;
    logic [15:0] last_day_reg;

    logic [31:0] last_sec_next;
    logic [31:0] last_tick_next;
    logic [7:0]  day_count_next;
    logic [15:0] last_day_next;
    logic [1:0]  decision_next;

    logic        advance;
    logic        in_fire;
    logic [50:0] day_prod;
    item_t       item_in;

    // Wall-clock day index, formed on the way into the input register
    assign day_prod = 51'(item_in.now_seconds[31:7]) * 51'(DAY_RECIP);

    assign item_in = '{
        command:              in_ch.command,
        dry_stress_flag:      in_ch.dry_stress_flag,
        moisture_permille:    in_ch.moisture_permille,
        sensor_ok:            in_ch.sensor_ok,
        tank_has_liquid:      in_ch.tank_has_liquid,
        now_seconds:          in_ch.now_seconds,
        tick_now:             in_ch.tick_now,
        last_response_failed: in_ch.last_response_failed,
        monitoring_mode:      in_ch.monitoring_mode
    };

    assign advance     = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic        synced;
        logic        dry;
        logic        gates_ok;
        logic        elapsed;
        logic        checks_ok;
        logic [31:0] tick_diff;
        logic [31:0] sec_diff;
        logic        day_changed;
        logic [7:0]  cnt;

        synced      = item_reg.now_seconds != NO_TIME;
        tick_diff   = item_reg.tick_now - last_tick_reg;
        sec_diff    = item_reg.now_seconds - last_sec_reg;
        day_changed = day_idx_reg != last_day_reg;
        dry         = item_reg.dry_stress_flag
                      && (item_reg.moisture_permille < cfg.dry_threshold_permille);
        gates_ok    = cfg.auto_enable && item_reg.sensor_ok && item_reg.tank_has_liquid;

        if (synced && (last_sec_reg != NO_TIME))
        begin
            // a clock that went backwards passes
            elapsed = (item_reg.now_seconds < last_sec_reg)
                      || (sec_diff >= cfg.min_interval_seconds);
        end
        else if ((last_sec_reg == NO_TIME) && (last_tick_reg == '0))
        begin
            elapsed = 1'b1;
        end
        else
        begin
            elapsed = tick_diff >= cfg.min_interval_ticks;
        end
        checks_ok = gates_ok && elapsed && !item_reg.last_response_failed;

        last_sec_next  = last_sec_reg;
        last_tick_next = last_tick_reg;
        last_day_next  = last_day_reg;
        cnt            = day_count_reg;
        decision_next  = DEC_HOLD;

        if (item_reg.command == CMD_REPORT)
        begin
            if (synced && day_changed)
            begin
                cnt           = '0;
                last_day_next = day_idx_reg;
            end
            last_sec_next  = item_reg.now_seconds;
            last_tick_next = item_reg.tick_now;
            if (cnt != 8'hFF)
            begin
                cnt = cnt + 8'd1;
            end
        end
        else if (!dry)
        begin
            decision_next = DEC_HOLD;
        end
        else if (!checks_ok)
        begin
            decision_next = DEC_BLOCKED;
        end
        else
        begin
            // roll the day only once the earlier interlocks pass
            if (synced)
            begin
                if (day_changed)
                begin
                    cnt           = '0;
                    last_day_next = day_idx_reg;
                end
            end
            else if (tick_diff >= TICKS_IN_DAY)
            begin
                cnt = '0;
            end
            if ((cnt >= cfg.max_daily_count) || !item_reg.monitoring_mode)
            begin
                decision_next = DEC_BLOCKED;
            end
            else
            begin
                decision_next = DEC_REQUEST;
            end
        end
        day_count_next = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            last_sec_reg  <= NO_TIME;
            last_tick_reg <= '0;
            day_count_reg <= '0;
            last_day_reg  <= NO_DAY;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (advance && in_vld_reg)
            begin
                last_sec_reg  <= last_sec_next;
                last_tick_reg <= last_tick_next;
                day_count_reg <= day_count_next;
                last_day_reg  <= last_day_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg    <= item_in;
            day_idx_reg <= day_prod[50:DAY_SHIFT];
        end
        if (advance && in_vld_reg)
        begin
            decision_reg <= decision_next;
            count_reg    <= day_count_next;
        end
    end

    assign out_ch.valid           = out_vld_reg;
    assign out_ch.decision        = decision_reg;
    assign out_ch.daily_count_now = count_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_vld_reg && out_vld_reg))
        else $error("input stalled with a free stage");

    a_report_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_vld_reg && (item_reg.command == CMD_REPORT))
        |=> (out_vld_reg && (decision_reg == DEC_HOLD) && (count_reg != 8'd0)))
        else $error("report beat gave a decision or a zero count");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_vld_reg) |=> (count_reg == day_count_reg))
        else $error("result count differs from stored day count");

    a_synced_report_day: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_vld_reg && (item_reg.command == CMD_REPORT)
         && (item_reg.now_seconds != NO_TIME))
        |=> (last_day_reg == $past(day_idx_reg)))
        else $error("synced report did not record its day");

endmodule

[sv/rate_limited_actuation_interlock.sv]
// Top level of the actuation interlock: APB configuration registers and the core.
// Depends on rlai_pkg, rlai_if.sv and rlai_core.
//
// Each input beat either asks for an actuation decision (hold, request or
// blocked) or reports that an actuation ran; every beat yields exactly one
// result beat carrying the decision and the day's actuation count after it.
// The block takes one beat per clock while the output is not stalled: an item
// is held in the input register, where the day index is formed by a reciprocal
// multiply, and the interval checks, day rollover and count update settle from
// there into the result register. A stalled output holds one result and
// one more input beat before ready drops. Write the configuration registers
// (byte addresses 0x00 to 0x10, 32-bit words) only while no beat is in flight.
module rate_limited_actuation_interlock (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rlai_pkg::CfgAddrW-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    rlai_in_if.sink                        in_ch,
    rlai_out_if.source                     out_ch
);
    import rlai_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dry_threshold_permille <= RST_DRY_THRESHOLD;
            cfg_reg.auto_enable            <= RST_AUTO_ENABLE;
            cfg_reg.min_interval_seconds   <= RST_MIN_INT_SECS;
            cfg_reg.min_interval_ticks     <= RST_MIN_INT_TICKS;
            cfg_reg.max_daily_count        <= RST_MAX_DAILY;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DRY_THRESHOLD: cfg_reg.dry_threshold_permille <= pwdata[9:0];
                REG_AUTO_ENABLE:   cfg_reg.auto_enable            <= pwdata[0];
                REG_MIN_INT_SECS:  cfg_reg.min_interval_seconds   <= pwdata;
                REG_MIN_INT_TICKS: cfg_reg.min_interval_ticks     <= pwdata;
                REG_MAX_DAILY:     cfg_reg.max_daily_count        <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DRY_THRESHOLD: prdata = 32'(cfg_reg.dry_threshold_permille);
            REG_AUTO_ENABLE:   prdata = 32'(cfg_reg.auto_enable);
            REG_MIN_INT_SECS:  prdata = cfg_reg.min_interval_seconds;
            REG_MIN_INT_TICKS: prdata = cfg_reg.min_interval_ticks;
            REG_MAX_DAILY:     prdata = 32'(cfg_reg.max_daily_count);
            default:           prdata = '0;
        endcase
    end

    rlai_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

[bench/tb_top.sv]
// Testbench for the rate-limited actuation interlock: directed interlock cases, count
// saturation, back-pressure and random phases, all checked against an in-bench predictor.
// Depends on rlai_pkg, rlai_if.sv and rate_limited_actuation_interlock.
module tb_top;
    import rlai_pkg::*;

    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] DAY0           = 32'd86_400_000;  // start of day 1000
    localparam int          HOLDOFF_CYCLES = 80;
    localparam int          STALL_LIMIT    = 2000;
    localparam int          DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [1:0] decision;
        logic [7:0] daily_count;
    } result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    rlai_in_if  in_if ();
    rlai_out_if out_if ();

    rate_limited_actuation_interlock dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    // predictor copy of the registers and the actuation history
    logic [9:0]  cfg_dry_thr;
    logic        cfg_auto_en;
    logic [31:0] cfg_gap_secs;
    logic [31:0] cfg_gap_ticks;
    logic [7:0]  cfg_day_quota;
    logic [31:0] act_secs;
    logic [31:0] act_tick;
    logic [7:0]  acts_today;
    logic [15:0] cur_day;

    result_t     pending_results[$];
    int          errors;
    int          n_items;
    int          n_checked;
    int          n_request;
    int          n_blocked;
    int          n_hold;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          holdoff_req;
    logic [31:0] sim_secs;
    logic [31:0] sim_ticks;
    logic [1:0]  prev_decision;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void roll_day(logic [31:0] now);
        logic [15:0] d;
        d = 16'(now / SECS_PER_DAY);
        if (d != cur_day)
        begin
            acts_today = '0;
            cur_day = d;
        end
    endfunction

    function automatic result_t predict_result(item_t it);
        result_t     r;
        logic [31:0] since_tick;
        logic        elapsed;
        r.decision = DEC_HOLD;
        since_tick = it.tick_now - act_tick;
        if (it.command == CMD_REPORT)
        begin
            if (it.now_seconds != NO_TIME)
                roll_day(it.now_seconds);
            act_secs = it.now_seconds;
            act_tick = it.tick_now;
            if (acts_today != 8'hFF)
                acts_today++;
        end
        else if (it.dry_stress_flag && it.moisture_permille < cfg_dry_thr)
        begin
            if (!cfg_auto_en || !it.sensor_ok || !it.tank_has_liquid)
                r.decision = DEC_BLOCKED;
            else
            begin
                // a clock that ran backwards counts as elapsed
                if (it.now_seconds != NO_TIME && act_secs != NO_TIME)
                    elapsed = (it.now_seconds < act_secs) ||
                              (it.now_seconds - act_secs >= cfg_gap_secs);
                else if (act_secs == NO_TIME && act_tick == '0)
                    elapsed = 1'b1;
                else
                    elapsed = since_tick >= cfg_gap_ticks;
                if (!elapsed || it.last_response_failed)
                    r.decision = DEC_BLOCKED;
                else
                begin
                    if (it.now_seconds != NO_TIME)
                        roll_day(it.now_seconds);
                    else if (since_tick >= TICKS_IN_DAY)
                        acts_today = '0;
                    if (acts_today >= cfg_day_quota || !it.monitoring_mode)
                        r.decision = DEC_BLOCKED;
                    else
                        r.decision = DEC_REQUEST;
                end
            end
        end
        r.daily_count = acts_today;
        return r;
    endfunction

    function automatic item_t good_eval(logic [31:0] now, logic [31:0] tick);
        item_t it;
        it.command              = CMD_EVALUATE;
        it.dry_stress_flag      = 1'b1;
        it.moisture_permille    = 10'd100;
        it.sensor_ok            = 1'b1;
        it.tank_has_liquid      = 1'b1;
        it.now_seconds          = now;
        it.tick_now             = tick;
        it.last_response_failed = 1'b0;
        it.monitoring_mode      = 1'b1;
        return it;
    endfunction

    function automatic item_t report_at(logic [31:0] now, logic [31:0] tick);
        item_t it;
        it = good_eval(now, tick);
        it.command = CMD_REPORT;
        return it;
    endfunction

    // mostly steps around the minimum gap, sometimes a whole day or a wild jump
    function automatic logic [31:0] clock_step(logic [31:0] gap, logic [31:0] day);
        logic [31:0] span;
        span = (gap > 32'h7FFF_FFFE) ? 32'hFFFF_FFFF : gap * 2 + 1;
        case ($urandom_range(15))
            0:       return $urandom();
            1:       return day;
            2:       return gap;
            3:       return gap - 1;
            default: return $urandom_range(span);
        endcase
    endfunction

    function automatic item_t random_item(bit synced);
        item_t it;
        sim_secs  += clock_step(cfg_gap_secs, SECS_PER_DAY);
        sim_ticks += clock_step(cfg_gap_ticks, TICKS_IN_DAY);
        // act on a granted request most of the time, like a real controller
        if (prev_decision == DEC_REQUEST && $urandom_range(9) < 8)
            it.command = CMD_REPORT;
        else if ($urandom_range(11) == 0)
            it.command = CMD_REPORT;
        else
            it.command = CMD_EVALUATE;
        it.dry_stress_flag = $urandom_range(19) != 0;
        if (cfg_dry_thr != 0 && $urandom_range(9) < 8)
            it.moisture_permille = 10'($urandom_range(cfg_dry_thr - 1));
        else
            it.moisture_permille = 10'($urandom_range(1023));
        it.sensor_ok            = $urandom_range(24) != 0;
        it.tank_has_liquid      = $urandom_range(24) != 0;
        it.last_response_failed = $urandom_range(24) == 0;
        it.monitoring_mode      = $urandom_range(19) != 0;
        it.tick_now             = sim_ticks;
        if ($urandom_range(19) == 0)
            synced = !synced;
        it.now_seconds = synced ? sim_secs : NO_TIME;
        if (synced && $urandom_range(29) == 0)
            it.now_seconds = sim_secs - $urandom_range(5000, 1);
        return it;
    endfunction

    task automatic send_item(input item_t it);
        result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid                <= 1'b1;
        in_if.command              <= it.command;
        in_if.dry_stress_flag      <= it.dry_stress_flag;
        in_if.moisture_permille    <= it.moisture_permille;
        in_if.sensor_ok            <= it.sensor_ok;
        in_if.tank_has_liquid      <= it.tank_has_liquid;
        in_if.now_seconds          <= it.now_seconds;
        in_if.tick_now             <= it.tick_now;
        in_if.last_response_failed <= it.last_response_failed;
        in_if.monitoring_mode      <= it.monitoring_mode;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        want = predict_result(it);
        pending_results.push_back(want);
        prev_decision = want.decision;
        n_items++;
    endtask

    // drop valid and hold until every result is back and the pipe is empty
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DRY_THRESHOLD: cfg_dry_thr   = value[9:0];
            REG_AUTO_ENABLE:   cfg_auto_en   = value[0];
            REG_MIN_INT_SECS:  cfg_gap_secs  = value;
            REG_MIN_INT_TICKS: cfg_gap_ticks = value;
            REG_MAX_DAILY:     cfg_day_quota = value[7:0];
            default: ;
        endcase
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_item(random_item((i / 50) % 2 == 0));
    endtask

    task automatic test_directed();
        item_t it;
        send_idle_pct  = 28;
        recv_stall_pct = 56;
        it = good_eval(DAY0, 32'd10);
        it.dry_stress_flag = 1'b0;
        send_item(it);
        it = good_eval(DAY0, 32'd10);
        it.moisture_permille = 10'd299;      // dry, but disabled after reset
        send_item(it);
        it.moisture_permille = 10'd300;      // at threshold is not dry
        send_item(it);
        it.moisture_permille = 10'd1023;
        send_item(it);

        cfg_write(REG_AUTO_ENABLE, 32'd1);
        it = good_eval(DAY0, 32'd10);
        it.sensor_ok = 1'b0;
        send_item(it);
        it = good_eval(DAY0, 32'd10);
        it.tank_has_liquid = 1'b0;
        send_item(it);
        it = good_eval(DAY0, 32'd10);
        it.last_response_failed = 1'b1;
        send_item(it);
        it = good_eval(DAY0, 32'd10);
        it.monitoring_mode = 1'b0;
        send_item(it);
        it = good_eval(DAY0, 32'd10);
        it.moisture_permille = 10'd0;
        send_item(it);

        // synced interval, backwards clock and daily quota
        send_item(report_at(DAY0, 32'd10));
        send_item(good_eval(DAY0 + 100, 32'd20));
        send_item(good_eval(DAY0 + 3600, 32'd30));
        send_item(good_eval(DAY0 - 50, 32'd40));
        send_item(report_at(DAY0 + 3600, 32'd50));
        send_item(report_at(DAY0 + 7200, 32'd60));
        send_item(good_eval(DAY0 + 10800, 32'd70));
        send_item(good_eval(DAY0 + SECS_PER_DAY, 32'd80));

        // unsynced interval across the tick wrap, then tick-based day rollover
        send_item(report_at(NO_TIME, 32'hFFFF_FF00));
        send_item(good_eval(NO_TIME, 32'hFFFF_FF00 + 32'd359999));
        send_item(good_eval(NO_TIME, 32'hFFFF_FF00 + 32'd360000));
        send_item(good_eval(DAY0 + 2 * SECS_PER_DAY, 32'hFFFF_FF00 + TICKS_IN_DAY));
        send_item(good_eval(NO_TIME, 32'hFFFF_FF00 + TICKS_IN_DAY));

        // a report at tick zero while unsynced looks like no actuation yet
        send_item(report_at(NO_TIME, 32'd0));
        send_item(good_eval(NO_TIME, 32'd5));
    endtask

    task automatic test_config_extremes();
        item_t it;
        cfg_write(REG_DRY_THRESHOLD, 32'd0);
        it = good_eval(DAY0 + 5 * SECS_PER_DAY, 32'd100);
        it.moisture_permille = 10'd0;
        send_item(it);
        cfg_write(REG_DRY_THRESHOLD, 32'd1000);
        cfg_write(REG_MIN_INT_SECS, 32'hFFFF_FFFF);
        cfg_write(REG_MIN_INT_TICKS, 32'hFFFF_FFFF);
        cfg_write(REG_MAX_DAILY, 32'd0);
        it = good_eval(DAY0 + 6 * SECS_PER_DAY, 32'd200);
        it.moisture_permille = 10'd999;
        send_item(it);
        send_item(report_at(DAY0 + 6 * SECS_PER_DAY, 32'd300));
        send_item(good_eval(DAY0 + 7 * SECS_PER_DAY, 32'd400));
        send_item(good_eval(DAY0 + 6 * SECS_PER_DAY - 1, 32'd500));
        send_item(good_eval(NO_TIME, 32'd300 + 32'hFFFF_FFFE));
    endtask

    task automatic test_random_defaults();
        send_idle_pct  = 28;
        recv_stall_pct = 56;
        cfg_write(REG_DRY_THRESHOLD, 32'd300);
        cfg_write(REG_AUTO_ENABLE, 32'd1);
        cfg_write(REG_MIN_INT_SECS, 32'd3600);
        cfg_write(REG_MIN_INT_TICKS, 32'd360000);
        cfg_write(REG_MAX_DAILY, 32'd3);
        sim_secs  = $urandom();
        sim_ticks = $urandom();
        run_random(200);
    endtask

    task automatic test_count_saturation();
        logic [31:0] tick;
        send_idle_pct  = 56;
        recv_stall_pct = 28;
        cfg_write(REG_MAX_DAILY, 32'd255);
        tick = $urandom();
        for (int i = 0; i < 260; i++)
        begin
            send_item(report_at(NO_TIME, tick));
            tick += $urandom_range(1000);
        end
        for (int i = 0; i < 4; i++)
            send_item(good_eval(NO_TIME, tick + cfg_gap_ticks + i));
        send_item(report_at(DAY0 + 30 * SECS_PER_DAY, tick));
    endtask

    task automatic test_random_wide();
        send_idle_pct  = 56;
        recv_stall_pct = 28;
        cfg_write(REG_DRY_THRESHOLD, 32'd1000);
        cfg_write(REG_MIN_INT_SECS, 32'd0);
        cfg_write(REG_MIN_INT_TICKS, 32'd0);
        sim_secs  = $urandom();
        sim_ticks = $urandom();
        run_random(200);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_write(REG_MAX_DAILY, 32'd2);
        cfg_write(REG_MIN_INT_SECS, 32'd600);
        // stall the result side while the sender keeps offering beats
        holdoff_req <= holdoff_req + 1;
        run_random(40);
        wait_idle();
        run_random(20);
    endtask

    task automatic test_random_strict();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_write(REG_DRY_THRESHOLD, 32'd1023);
        cfg_write(REG_MIN_INT_SECS, SECS_PER_DAY);
        cfg_write(REG_MIN_INT_TICKS, TICKS_IN_DAY);
        cfg_write(REG_MAX_DAILY, 32'd1);
        sim_secs  = $urandom();
        sim_ticks = $urandom();
        run_random(170);
        cfg_write(REG_AUTO_ENABLE, 32'd0);
        run_random(30);
    endtask

    // result side: check each beat against the oldest prediction
    initial
    begin
        result_t want;
        int      hold_left;
        int      holdoff_seen;
        hold_left    = 0;
        holdoff_seen = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            begin
                n_checked++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing pending: decision %0d count %0d",
                             $time, out_if.decision, out_if.daily_count_now);
                end
                else
                begin
                    want = pending_results.pop_front();
                    case (want.decision)
                        DEC_REQUEST: n_request++;
                        DEC_BLOCKED: n_blocked++;
                        default:     n_hold++;
                    endcase
                    if (out_if.decision !== want.decision)
                    begin
                        errors++;
                        $display("%0t: decision mismatch: expected %0d, actual %0d",
                                 $time, want.decision, out_if.decision);
                    end
                    if (out_if.daily_count_now !== want.daily_count)
                    begin
                        errors++;
                        $display("%0t: daily count mismatch: expected %0d, actual %0d",
                                 $time, want.daily_count, out_if.daily_count_now);
                    end
                end
            end
            if (holdoff_req != holdoff_seen)
            begin
                holdoff_seen = holdoff_req;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: give up after a long stretch with no beat on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n                      = 1'b0;
        psel                       = 1'b0;
        penable                    = 1'b0;
        pwrite                     = 1'b0;
        paddr                      = '0;
        pwdata                     = '0;
        in_if.valid                = 1'b0;
        in_if.command              = CMD_EVALUATE;
        in_if.dry_stress_flag      = 1'b0;
        in_if.moisture_permille    = '0;
        in_if.sensor_ok            = 1'b0;
        in_if.tank_has_liquid      = 1'b0;
        in_if.now_seconds          = '0;
        in_if.tick_now             = '0;
        in_if.last_response_failed = 1'b0;
        in_if.monitoring_mode      = 1'b0;
        errors         = 0;
        n_items        = 0;
        n_checked      = 0;
        n_request      = 0;
        n_blocked      = 0;
        n_hold         = 0;
        holdoff_req    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        prev_decision  = DEC_HOLD;
        sim_secs       = '0;
        sim_ticks      = '0;
        cfg_dry_thr    = RST_DRY_THRESHOLD;
        cfg_auto_en    = RST_AUTO_ENABLE;
        cfg_gap_secs   = RST_MIN_INT_SECS;
        cfg_gap_ticks  = RST_MIN_INT_TICKS;
        cfg_day_quota  = RST_MAX_DAILY;
        act_secs       = NO_TIME;
        act_tick       = '0;
        acts_today     = '0;
        cur_day        = NO_DAY;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_random_defaults();
        test_count_saturation();
        test_random_wide();
        test_backpressure();
        test_random_strict();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items: interlock cases, quota saturation, stalls, random phases.",
                 n_items);
        $display("Checked %0d results: %0d request, %0d blocked, %0d hold.",
                 n_checked, n_request, n_blocked, n_hold);
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/rlai_pkg.sv
sv/rlai_if.sv
sv/rlai_core.sv
sv/rate_limited_actuation_interlock.sv
bench/tb_top.sv
